// File: rtl/assert_macros.svh
// Assertion macros shared by the pacer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ATP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define ATP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/atp_pkg.sv
// Types and constants of the allocation tax pacer.
package atp_pkg;
    localparam logic [2:0] OP_CLAIM  = 3'd0;
    localparam logic [2:0] OP_FORCED = 3'd1;
    localparam logic [2:0] OP_UNPACE = 3'd2;
    localparam logic [2:0] OP_MARK   = 3'd3;
    localparam logic [2:0] OP_EVAC   = 3'd4;
    localparam logic [2:0] OP_UPDREF = 3'd5;
    localparam logic [2:0] OP_IDLE   = 3'd6;
    localparam logic [2:0] OP_RESET  = 3'd7;

    localparam logic [1:0] CFG_CYCLE_SLACK = 2'd0;
    localparam logic [1:0] CFG_IDLE_SLACK  = 2'd1;
    localparam logic [1:0] CFG_SURCHARGE   = 2'd2;
    localparam logic [1:0] CFG_CAPACITY    = 2'd3;

    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [47:0] BUDGET_MAX = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] BUDGET_MIN = 48'h8000_0000_0000;
    localparam int unsigned PCT = 100;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] alloc_words;
        logic [31:0] ticket_epoch;
        logic [47:0] work_bytes;
        logic [47:0] free_bytes;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [47:0] budget_words;
        logic [31:0] epoch_now;
        logic [31:0] rate_q16_16;
    } t_out_item;

    // Divider request and status between the sequencer and the divider.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [47:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } t_div_rsp;
endpackage

// File: rtl/atp_divider.sv
// Radix-2 restoring divider, 64-bit dividend by 48-bit divisor, one bit a cycle.
module atp_divider (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  atp_pkg::t_div_req  i_req,
    output atp_pkg::t_div_rsp  o_rsp
);
    logic [63:0] r_quo, n_quo;
    logic [48:0] r_rem, n_rem;
    logic [47:0] r_dvs;
    logic [6:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [48:0] w_sh;
    logic [48:0] w_diff;

    always_comb begin
        w_sh   = {r_rem[47:0], r_quo[63]};
        w_diff = w_sh - {1'b0, r_dvs};
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_req.start) begin
            n_quo  = i_req.dividend;
            n_rem  = '0;
            n_cnt  = 7'd64;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (!w_diff[48]) begin
                n_rem = w_diff;
                n_quo = {r_quo[62:0], 1'b1};
            end else begin
                n_rem = w_sh;
                n_quo = {r_quo[62:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_req.start) r_dvs <= i_req.divisor;
    end

    assign o_rsp.busy     = r_busy;
    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;
endmodule

// File: rtl/atp_mul.sv
// Shared 32x32 unsigned multiplier with a registered product.
module atp_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_p
);
    logic [63:0] r_p;
    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end
    assign o_p = r_p;
endmodule

// File: rtl/allocation_tax_pacer_unit.sv
// Top level of the allocation tax pacer: sequencer, state and configuration.
// Allocation tax pacer.
// Input channel: i_in_valid / o_in_stall carry one t_in_item per transfer.
// Output channel: o_out_valid / i_out_stall carry one t_out_item per transfer.
// Configuration: i_cfg_we writes register i_cfg_index with i_cfg_data; write
// only while the block is idle.
// Claims, forced claims and unpaces make one pass through the shared 32x32
// multiplier between transfer in and result valid; a new item is taken only
// once the sequencer is back in idle. Phase setups (mark, evac, update refs) are
// dominated by the one-bit-a-cycle 64/48 divider plus ten multiplier passes;
// idle and reset use multiplier passes only.
// One item is processed at a time; o_in_stall is high from transfer in until
// the sequencer is back in idle. The result sits in an output register, so a
// stalled receiver just holds it while the next item runs; that item waits in
// its last step until the output register is free.
// Synchronous reset: budget 0, rate 1.0, epoch 0, registers to defaults.
// All wide products (48x7, 49x32, 64x16, 64x64) are built from 32x32 partial products
// accumulated over several passes through the one multiplier.
module allocation_tax_pacer_unit #(
    parameter int LOG_WORD_BYTES = 3
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  atp_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output atp_pkg::t_out_item  o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data
);
    `include "assert_macros.svh"

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_CMUL  = 5'd1;  // words * rate issued
    localparam logic [4:0] S_CAPP  = 5'd2;  // apply charge
    localparam logic [4:0] S_NT0   = 5'd3;  // free*slack issued (lo)
    localparam logic [4:0] S_NT1   = 5'd4;  // free*slack (hi)
    localparam logic [4:0] S_NTD   = 5'd5;  // finish free*slack; /100 via reciprocal follows
    localparam logic [4:0] S_NTE   = 5'd6;
    localparam logic [4:0] S_NTF   = 5'd7;
    localparam logic [4:0] S_DIVS  = 5'd8;
    localparam logic [4:0] S_DIVW  = 5'd9;
    localparam logic [4:0] S_SC0   = 5'd10; // base*surcharge
    localparam logic [4:0] S_SC1   = 5'd11;
    localparam logic [4:0] S_SC2   = 5'd12;
    localparam logic [4:0] S_RS0   = 5'd13; // untaxed*rate
    localparam logic [4:0] S_RS1   = 5'd14;
    localparam logic [4:0] S_RS2   = 5'd15;
    localparam logic [4:0] S_RS3   = 5'd16;
    localparam logic [4:0] S_OUT   = 5'd17;
    localparam logic [4:0] S_ID0   = 5'd18; // capacity/100 path
    localparam logic [4:0] S_ID1   = 5'd19;
    localparam logic [4:0] S_ID2   = 5'd20;
    localparam logic [4:0] S_ID3   = 5'd21;

    // ceil(2^62/100): (x*M)>>62 equals x/100 for every x below 2^55.
    localparam logic [63:0] RECIP100 = 64'd46116860184273880; // ceil(2^62/100)

    logic [6:0]  r_cyc_slack, r_idle_slack;
    logic [15:0] r_surcharge;
    logic [47:0] r_capacity;

    logic [47:0] r_budget, n_budget;
    logic [31:0] r_rate, n_rate;
    logic [31:0] r_epoch, n_epoch;

    logic [4:0]  r_st, n_st;
    atp_pkg::t_in_item  r_item, n_item;
    logic        r_ovalid, n_ovalid;
    logic        r_granted, n_granted;
    atp_pkg::t_out_item r_out, n_out;

    // Datapath scratch registers
    logic [127:0] r_acc, n_acc;   // accumulator of partial products
    logic [63:0]  r_x, n_x;       // operand under multiplication
    logic [48:0]  r_nt, n_nt;     // untaxed bytes, may exceed free space
    logic [31:0]  r_newrate, n_newrate;
    logic [2:0]   r_k, n_k;       // partial-product index

    logic [31:0] w_ma, w_mb;
    logic [63:0] w_mp;

    atp_pkg::t_div_req w_dreq;
    atp_pkg::t_div_rsp w_drsp;

    atp_mul u_mul (.i_clk(i_clk), .i_a(w_ma), .i_b(w_mb), .o_p(w_mp));
    atp_divider u_div (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_dreq), .o_rsp(w_drsp));

    wire w_in_acc  = i_in_valid && !o_in_stall;
    wire w_out_acc = r_ovalid && !i_out_stall;

    assign o_in_stall = (r_st != S_IDLE);

    // Charge: max(1, (words*rate)>>16), fits in 48 bits.
    logic [47:0] w_charge;
    always_comb begin
        w_charge = w_mp[63:16];
        if (w_charge == '0) w_charge = 48'd1;
    end

    // Budget arithmetic on 50 bits: a 48-bit charge off a negative budget
    // must not wrap before the limits are checked.
    logic signed [49:0] w_bsum;

    // Limits applied to base (in r_x) during rate computation
    logic [63:0] w_base;
    always_comb begin
        w_base = w_drsp.quotient;
        if (w_base > 64'h1_0000_0000_0000) w_base = 64'h1_0000_0000_0000;
        if (r_item.operation == atp_pkg::OP_EVAC) w_base = {w_base[62:0], 1'b0};
        if (w_base > 64'h1_0000_0000_0000) w_base = 64'h1_0000_0000_0000;
        if (r_item.operation != atp_pkg::OP_MARK && w_base < 64'h1_0000)
            w_base = 64'h1_0000;
    end

    // Multiplier operand selection per state
    always_comb begin
        w_ma = '0;
        w_mb = '0;
        case (r_st)
            S_CMUL: begin
                w_ma = r_item.alloc_words; w_mb = r_rate;
            end
            S_NT0, S_NT1: begin
                w_ma = (r_k == 3'd0) ? r_item.free_bytes[31:0]
                                     : {16'd0, r_item.free_bytes[47:32]};
                w_mb = {25'd0, r_cyc_slack};
            end
            S_NTD, S_NTE, S_NTF, S_ID1, S_ID2: begin
                // x (<2^55) * RECIP100, four 32x32 partials, index r_k
                w_ma = r_k[1] ? r_x[63:32] : r_x[31:0];
                w_mb = r_k[0] ? RECIP100[63:32] : RECIP100[31:0];
            end
            S_ID3: begin
                // capacity/100 (<2^42) * idle slack, low then high half
                w_ma = r_k[0] ? r_x[63:32] : r_x[31:0];
                w_mb = {25'd0, r_idle_slack};
            end
            S_SC0, S_SC1, S_SC2: begin
                w_ma = r_k[0] ? r_x[63:32] : r_x[31:0];
                w_mb = {16'd0, r_surcharge};
            end
            S_RS0, S_RS1, S_RS2, S_RS3: begin
                w_ma = r_k[1] ? {15'd0, r_nt[48:32]} : r_nt[31:0];
                w_mb = r_k[0] ? 32'd0 : r_newrate;
            end
            default: begin
                w_ma = '0; w_mb = '0;
            end
        endcase
    end

    logic [47:0] w_init;
    logic [127:0] w_sh;

    always_comb begin
        n_st      = r_st;
        n_item    = r_item;
        n_ovalid  = r_ovalid;
        n_granted = r_granted;
        n_out     = r_out;
        n_budget  = r_budget;
        n_rate    = r_rate;
        n_epoch   = r_epoch;
        n_acc     = r_acc;
        n_x       = r_x;
        n_nt      = r_nt;
        n_newrate = r_newrate;
        n_k       = r_k;
        w_dreq    = '0;
        w_bsum    = '0;
        w_init    = '0;
        w_sh      = '0;
        if (w_out_acc) n_ovalid = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_item    = i_in_data;
                    n_granted = 1'b1;
                    n_k       = '0;
                    n_acc     = '0;
                    case (i_in_data.operation)
                        atp_pkg::OP_CLAIM, atp_pkg::OP_FORCED, atp_pkg::OP_UNPACE:
                            n_st = S_CMUL;
                        atp_pkg::OP_IDLE: begin
                            n_x  = {16'd0, r_capacity};
                            n_st = S_ID1;
                        end
                        atp_pkg::OP_RESET: begin
                            n_nt = {1'b0, r_capacity};
                            n_newrate = atp_pkg::ONE_Q16;
                            n_st = S_RS0;
                        end
                        default: n_st = S_NT0;
                    endcase
                end
            end
            S_CMUL: n_st = S_CAPP;
            S_CAPP: begin
                case (r_item.operation)
                    atp_pkg::OP_CLAIM: begin
                        w_bsum = $signed({{2{r_budget[47]}}, r_budget}) -
                                 $signed({2'b00, w_charge});
                        if (w_bsum[49]) n_granted = 1'b0;
                        else n_budget = w_bsum[47:0];
                    end
                    atp_pkg::OP_FORCED: begin
                        w_bsum = $signed({{2{r_budget[47]}}, r_budget}) -
                                 $signed({2'b00, w_charge});
                        if (w_bsum[49:47] != 3'b000 && w_bsum[49:47] != 3'b111)
                            n_budget = atp_pkg::BUDGET_MIN;
                        else n_budget = w_bsum[47:0];
                    end
                    default: begin
                        if (r_item.ticket_epoch == r_epoch) begin
                            w_bsum = $signed({{2{r_budget[47]}}, r_budget}) +
                                     $signed({2'b00, w_charge});
                            if (w_bsum[49:47] != 3'b000 && w_bsum[49:47] != 3'b111)
                                n_budget = atp_pkg::BUDGET_MAX;
                            else n_budget = w_bsum[47:0];
                        end
                    end
                endcase
                n_st = S_OUT;
            end
            // free * slack: product below 2^55, two partials (lo, hi<<32)
            S_NT0: begin
                n_k  = 3'd1;
                n_st = S_NT1;
            end
            S_NT1: begin
                n_acc = {64'd0, w_mp};
                n_st  = S_NTD;
                n_k   = 3'd2;
            end
            S_NTD: begin
                // w_mp = hi*slack; finish x, reciprocal multiply follows
                n_x  = r_acc[63:0] + {w_mp[31:0], 32'd0};
                n_acc = '0;
                n_k  = 3'd0;
                n_st = S_NTE;
            end
            S_NTE, S_ID1: begin
                // issue partial r_k; its product accumulates in the cycle after
                // (partial 0 unshifted, partials 1 and 2 at 32, partial 3 at 64)
                if (r_k != 3'd0) begin
                    n_acc = r_acc + ({64'd0, w_mp} << ((r_k == 3'd1) ? 7'd0 : 7'd32));
                end
                n_k = r_k + 3'd1;
                if (r_k == 3'd3) n_st = (r_st == S_NTE) ? S_NTF : S_ID2;
            end
            S_NTF, S_ID2: begin
                w_sh = r_acc + ({64'd0, w_mp} << 64);
                n_acc = '0;
                if (r_st == S_NTF) begin
                    n_nt = w_sh[110:62];
                    w_dreq.start = 1'b1;
                    w_dreq.dividend = {r_item.work_bytes, 16'd0};
                    w_dreq.divisor = ({1'b0, r_item.free_bytes} > w_sh[110:62]) ?
                        r_item.free_bytes - w_sh[109:62] : 48'd1;
                    n_st = S_DIVW;
                end else begin
                    n_x  = {16'd0, w_sh[109:62]};
                    n_st = S_ID3;
                    n_k  = '0;
                end
            end
            S_ID3: begin
                n_k = r_k + 3'd1;
                if (r_k == 3'd1) n_acc = {64'd0, w_mp};
                if (r_k == 3'd2) begin
                    n_nt = r_acc[48:0] + {w_mp[16:0], 32'd0};
                    n_newrate = atp_pkg::ONE_Q16;
                    n_acc = '0;
                    n_k = '0;
                    n_st = S_RS0;
                end
            end
            S_DIVS: n_st = S_DIVW;
            S_DIVW: begin
                if (w_drsp.done) begin
                    n_x = w_base;
                    n_k = '0;
                    n_st = S_SC0;
                end
            end
            S_SC0: begin
                n_k = 3'd1; n_st = S_SC1;
            end
            S_SC1: begin
                n_acc = {64'd0, w_mp};
                n_st = S_SC2;
            end
            S_SC2: begin
                w_sh = r_acc + ({64'd0, w_mp} << 32);
                w_sh = w_sh >> 8;
                n_newrate = (w_sh[127:32] != '0) ? 32'hFFFF_FFFF : w_sh[31:0];
                n_k = '0;
                n_acc = '0;
                n_st = S_RS0;
            end
            // untaxed(49) * rate(32): partials nt_lo*r, nt_hi*r
            S_RS0: begin
                n_k = 3'd2; n_st = S_RS1;
            end
            S_RS1: begin
                n_acc = {64'd0, w_mp};
                n_st = S_RS2;
            end
            S_RS2: begin
                w_sh = r_acc + ({64'd0, w_mp} << 32);
                n_acc = w_sh;
                n_st = S_RS3;
            end
            S_RS3: begin
                // t = (nt*rate)>>16 ; sat if t >= 2^62
                w_sh = r_acc >> 16;
                if (w_sh[127:62] != '0) w_init = atp_pkg::BUDGET_MAX;
                else begin
                    w_sh = w_sh >> LOG_WORD_BYTES;
                    w_init = (w_sh[127:47] != '0) ? atp_pkg::BUDGET_MAX : w_sh[47:0];
                end
                n_budget = w_init;
                n_rate   = r_newrate;
                n_epoch  = r_epoch + 32'd1;
                n_st     = S_OUT;
            end
            S_OUT: begin
                // hold here while the previous result still waits
                if (!r_ovalid || w_out_acc) begin
                    n_ovalid           = 1'b1;
                    n_out.granted      = r_granted;
                    n_out.budget_words = r_budget;
                    n_out.epoch_now    = r_epoch;
                    n_out.rate_q16_16  = r_rate;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st         <= S_IDLE;
            r_ovalid     <= 1'b0;
            r_budget     <= '0;
            r_rate       <= atp_pkg::ONE_Q16;
            r_epoch      <= '0;
            r_cyc_slack  <= 7'd10;
            r_idle_slack <= 7'd2;
            r_surcharge  <= 16'd282;
            r_capacity   <= '0;
        end else begin
            r_st     <= n_st;
            r_ovalid <= n_ovalid;
            r_budget <= n_budget;
            r_rate   <= n_rate;
            r_epoch  <= n_epoch;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    atp_pkg::CFG_CYCLE_SLACK: r_cyc_slack  <= i_cfg_data[6:0];
                    atp_pkg::CFG_IDLE_SLACK:  r_idle_slack <= i_cfg_data[6:0];
                    atp_pkg::CFG_SURCHARGE:   r_surcharge  <= i_cfg_data[15:0];
                    default:                  r_capacity   <= i_cfg_data;
                endcase
            end
        end
        r_item    <= n_item;
        r_granted <= n_granted;
        r_out     <= n_out;
        r_acc     <= n_acc;
        r_x       <= n_x;
        r_nt      <= n_nt;
        r_newrate <= n_newrate;
        r_k       <= n_k;
    end

    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

    `ATP_ASSERT_IMP(a_busy_stall, i_clk, i_rst_n, r_st != S_IDLE, o_in_stall, "input taken while busy")
    `ATP_ASSERT_NEXT(a_hold_out, i_clk, i_rst_n, r_ovalid && i_out_stall, r_ovalid && $stable(r_out), "stalled result changed")
    `ATP_ASSERT_IMP(a_div_idle, i_clk, i_rst_n, r_st == S_IDLE, !w_drsp.busy, "divider busy while idle")
endmodule

// File: tb/pacer_checker.sv
// Checker for the allocation tax pacer: tracks budget, rate and epoch and compares results.
module pacer_checker #(
    parameter int LOG_WORD_BYTES = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  atp_pkg::t_in_item  i_in_data,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  atp_pkg::t_out_item i_out_data,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [47:0]        i_cfg_data,
    output int                 o_errors,
    output int                 o_pending,
    output int                 o_checked,
    output int                 o_denied
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint BUDGET_HI = 64'sd140737488355327;
    localparam longint BUDGET_LO = -64'sd140737488355328;

    bit [6:0]  cycle_slack;
    bit [6:0]  idle_slack;
    bit [15:0] surcharge;
    bit [47:0] capacity;
    longint    budget;
    bit [31:0] cur_rate;
    bit [31:0] epoch;
    atp_pkg::t_out_item awaited_results[$];

    function automatic longint clamp_budget(longint v);
        if (v > BUDGET_HI) return BUDGET_HI;
        if (v < BUDGET_LO) return BUDGET_LO;
        return v;
    endfunction

    function automatic longint charge_of(bit [31:0] words);
        bit [63:0] c;
        c = (64'(words) * 64'(cur_rate)) >> 16;
        if (c < 1) c = 1;
        return longint'(c);
    endfunction

    // Start a new epoch: budget is the untaxed space converted at the new rate.
    function automatic void restart_epoch(bit [63:0] untaxed, bit [31:0] rate);
        bit [127:0] words;
        words = ((128'(untaxed) * 128'(rate)) >> 16) >> LOG_WORD_BYTES;
        budget = (words > 128'(BUDGET_HI)) ? BUDGET_HI : longint'(words);
        cur_rate = rate;
        epoch = epoch + 32'd1;
    endfunction

    function automatic void setup_phase(bit [2:0] op, bit [47:0] work, bit [47:0] free_b);
        bit [63:0] untaxed;
        bit [63:0] taxable;
        bit [63:0] base;
        bit [63:0] rate;
        untaxed = 64'(free_b) * 64'(cycle_slack) / 64'(atp_pkg::PCT);
        taxable = (64'(free_b) > untaxed) ? 64'(free_b) - untaxed : 64'd0;
        if (taxable < 1) taxable = 1;
        base = (64'(work) << 16) / taxable;
        if (base > (64'd1 << 48)) base = 64'd1 << 48;
        if (op == atp_pkg::OP_EVAC) base = base * 2;
        if (base > (64'd1 << 48)) base = 64'd1 << 48;
        if (op != atp_pkg::OP_MARK && base < 64'(atp_pkg::ONE_Q16))
            base = 64'(atp_pkg::ONE_Q16);
        rate = (base * 64'(surcharge)) >> 8;
        if (rate > 64'hFFFF_FFFF) rate = 64'hFFFF_FFFF;
        restart_epoch(untaxed, rate[31:0]);
    endfunction

    function automatic atp_pkg::t_out_item pace_step(atp_pkg::t_in_item it);
        atp_pkg::t_out_item r;
        longint charge;
        r.granted = 1'b1;
        case (it.operation)
            atp_pkg::OP_CLAIM: begin
                charge = charge_of(it.alloc_words);
                if (budget < charge) r.granted = 1'b0;
                else budget = budget - charge;
            end
            atp_pkg::OP_FORCED: begin
                budget = clamp_budget(budget - charge_of(it.alloc_words));
            end
            atp_pkg::OP_UNPACE: begin
                if (it.ticket_epoch == epoch)
                    budget = clamp_budget(budget + charge_of(it.alloc_words));
            end
            atp_pkg::OP_MARK, atp_pkg::OP_EVAC, atp_pkg::OP_UPDREF: begin
                setup_phase(it.operation, it.work_bytes, it.free_bytes);
            end
            atp_pkg::OP_IDLE: begin
                restart_epoch(64'(capacity / 48'(atp_pkg::PCT)) * 64'(idle_slack),
                              atp_pkg::ONE_Q16);
            end
            default: begin
                restart_epoch(64'(capacity), atp_pkg::ONE_Q16);
            end
        endcase
        r.budget_words = budget[47:0];
        r.epoch_now = epoch;
        r.rate_q16_16 = cur_rate;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    always @(posedge i_clk) begin
        atp_pkg::t_out_item want;
        if (!i_rst_n) begin
            cycle_slack = 7'd10;
            idle_slack = 7'd2;
            surcharge = 16'd282;
            capacity = 48'd0;
            budget = 0;
            cur_rate = atp_pkg::ONE_Q16;
            epoch = 32'd0;
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    atp_pkg::CFG_CYCLE_SLACK: cycle_slack = i_cfg_data[6:0];
                    atp_pkg::CFG_IDLE_SLACK:  idle_slack = i_cfg_data[6:0];
                    atp_pkg::CFG_SURCHARGE:   surcharge = i_cfg_data[15:0];
                    default:                  capacity = i_cfg_data;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                awaited_results.push_back(pace_step(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (awaited_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_out_data), 64'd0);
                end else begin
                    want = awaited_results.pop_front();
                    o_checked++;
                    if (!want.granted) o_denied++;
                    if (i_out_data.granted !== want.granted)
                        report_mismatch("granted", 64'(i_out_data.granted),
                                        64'(want.granted));
                    if (i_out_data.budget_words !== want.budget_words)
                        report_mismatch("budget_words", 64'(i_out_data.budget_words),
                                        64'(want.budget_words));
                    if (i_out_data.epoch_now !== want.epoch_now)
                        report_mismatch("epoch_now", 64'(i_out_data.epoch_now),
                                        64'(want.epoch_now));
                    if (i_out_data.rate_q16_16 !== want.rate_q16_16)
                        report_mismatch("rate_q16_16", 64'(i_out_data.rate_q16_16),
                                        64'(want.rate_q16_16));
                end
            end
        end
        o_pending <= awaited_results.size();
    end
endmodule

// File: tb/allocation_tax_pacer_unit_tb.sv
// Testbench top for the allocation tax pacer: stimulus, stalls, verdict.
module allocation_tax_pacer_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    atp_pkg::t_in_item  i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    atp_pkg::t_out_item o_out_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [47:0] i_cfg_data;

    int errors;
    int pending;
    int checked;
    int denied;

    // Idle and stall odds in percent, changed per phase.
    int unsigned send_gap_pct;
    int unsigned recv_stall_pct;
    // Epoch the block will hold when the next item runs; items run in order.
    bit [31:0] epoch_ahead;
    int sent;

    allocation_tax_pacer_unit #(.LOG_WORD_BYTES(3)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data)
    );

    pacer_checker #(.LOG_WORD_BYTES(3)) checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .i_in_stall(o_in_stall), .i_in_data(i_in_data),
        .i_out_valid(o_out_valid), .i_out_stall(i_out_stall), .i_out_data(o_out_data),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_errors(errors), .o_pending(pending), .o_checked(checked), .o_denied(denied)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Stall the result side at random; hold off during reset.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // Hand one request to the block. Keep valid high across back-to-back transfers,
    // drop it only when a gap is drawn.
    task automatic send_request(bit [2:0] op, bit [31:0] words, bit [31:0] ticket,
                                bit [47:0] work, bit [47:0] free_b);
        int gaps;
        bit taken;
        gaps = 0;
        while ($urandom_range(0, 99) < send_gap_pct && gaps < 40) gaps++;
        if (gaps > 0) begin
            i_in_valid <= 1'b0;
            repeat (gaps) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= '{operation: op, alloc_words: words, ticket_epoch: ticket,
                       work_bytes: work, free_bytes: free_b};
        // Sample stall mid-cycle so the edge decision is race free.
        do begin
            @(negedge i_clk);
            taken = !o_in_stall;
            @(posedge i_clk);
        end while (!taken);
        if (op >= atp_pkg::OP_MARK) epoch_ahead = epoch_ahead + 32'd1;
        sent++;
    endtask

    // Drop valid and wait until every result is back, then let the block settle.
    task automatic drain;
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [47:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic bit [47:0] rand_bytes();
        bit [63:0] v;
        v = {$urandom, $urandom};
        return v[47:0] >> $urandom_range(0, 47);
    endfunction

    function automatic bit [31:0] rand_words();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 64);
            1: return $urandom_range(0, 1 << 20);
            2: return $urandom >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // Mostly claims, forced claims and unpaces with live tickets; phase setups
    // and restarts sprinkled in to move the rate and the epoch around.
    task automatic random_request;
        int pick;
        bit [2:0] op;
        bit [31:0] ticket;
        pick = $urandom_range(0, 99);
        if (pick < 35) op = atp_pkg::OP_CLAIM;
        else if (pick < 50) op = atp_pkg::OP_FORCED;
        else if (pick < 72) op = atp_pkg::OP_UNPACE;
        else op = 3'($urandom_range(atp_pkg::OP_MARK, atp_pkg::OP_RESET));
        case ($urandom_range(0, 9))
            0: ticket = $urandom;
            1: ticket = epoch_ahead - 32'd1;
            default: ticket = epoch_ahead;
        endcase
        send_request(op, rand_words(), ticket, rand_bytes(), rand_bytes());
    endtask

    initial begin
        int unsigned gap_set[4];
        int unsigned stall_set[4];
        gap_set = '{0, 69, 0, 37};
        stall_set = '{0, 0, 69, 37};
        i_rst_n <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_data <= '0;
        i_cfg_we <= 1'b0;
        i_cfg_index <= atp_pkg::CFG_CYCLE_SLACK;
        i_cfg_data <= '0;
        send_gap_pct = 0;
        recv_stall_pct = 0;
        epoch_ahead = 32'd0;
        sent = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty budget denies even a zero-word claim (charge floors at one).
        send_request(atp_pkg::OP_CLAIM, 32'd0, 32'd0, 48'd0, 48'd0);
        send_request(atp_pkg::OP_FORCED, 32'hFFFF_FFFF, 32'd0, 48'd0, 48'd0);
        drain();
        write_reg(atp_pkg::CFG_SURCHARGE, 48'hFFFF);
        write_reg(atp_pkg::CFG_CAPACITY, 48'hFFFF_FFFF_FFFF);
        // Restart at full capacity: budget is the capacity in words, below the limit.
        send_request(atp_pkg::OP_RESET, 32'd0, 32'd0, '1, '1);
        // Huge live set over one free byte: rate saturates.
        send_request(atp_pkg::OP_MARK, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 48'd1);
        // Forced claim at the saturated rate pins the budget at its floor.
        send_request(atp_pkg::OP_FORCED, 32'hFFFF_FFFF, 32'd0, 48'd0, 48'd0);
        repeat (3) send_request(atp_pkg::OP_UNPACE, 32'hFFFF_FFFF, epoch_ahead, 48'd0, 48'd0);
        // Stale ticket leaves the budget alone.
        send_request(atp_pkg::OP_UNPACE, 32'hFFFF_FFFF, epoch_ahead + 32'd5, 48'd0, 48'd0);
        send_request(atp_pkg::OP_CLAIM, 32'hFFFF_FFFF, 32'd0, 48'd0, 48'd0);
        send_request(atp_pkg::OP_CLAIM, 32'd1, 32'd0, 48'd0, 48'd0);
        send_request(atp_pkg::OP_EVAC, 32'd0, 32'd0, 48'd0, 48'hFFFF_FFFF_FFFF);
        send_request(atp_pkg::OP_UPDREF, 32'd0, 32'd0, 48'd0, 48'd0);
        send_request(atp_pkg::OP_MARK, 32'd0, 32'd0, 48'd0, 48'hFFFF_FFFF_FFFF);
        send_request(atp_pkg::OP_IDLE, 32'd0, 32'd0, 48'd0, 48'd0);
        drain();
        // Slack above one hundred: taxable part collapses to one byte.
        write_reg(atp_pkg::CFG_CYCLE_SLACK, 48'd127);
        write_reg(atp_pkg::CFG_IDLE_SLACK, 48'd127);
        send_request(atp_pkg::OP_MARK, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF);
        send_request(atp_pkg::OP_IDLE, 32'd0, 32'd0, 48'd0, 48'd0);
        send_request(atp_pkg::OP_EVAC, 32'd0, 32'd0, 48'hFFFF_FFFF_FFFF, 48'd1);
        send_request(atp_pkg::OP_CLAIM, 32'h0000_0100, 32'd0, 48'd0, 48'd0);

        // Random phases, each with its own register setting and idle pattern.
        for (int ph = 0; ph < 4; ph++) begin
            drain();
            case (ph)
                0: begin
                    write_reg(atp_pkg::CFG_CYCLE_SLACK, 48'd0);
                    write_reg(atp_pkg::CFG_IDLE_SLACK, 48'd0);
                    write_reg(atp_pkg::CFG_SURCHARGE, 48'd0);
                    write_reg(atp_pkg::CFG_CAPACITY, 48'd0);
                end
                1: begin
                    write_reg(atp_pkg::CFG_CYCLE_SLACK, 48'd100);
                    write_reg(atp_pkg::CFG_IDLE_SLACK, 48'd100);
                    write_reg(atp_pkg::CFG_SURCHARGE, 48'hFFFF);
                    write_reg(atp_pkg::CFG_CAPACITY, 48'hFFFF_FFFF_FFFF);
                end
                2: begin
                    write_reg(atp_pkg::CFG_CYCLE_SLACK, 48'($urandom_range(0, 127)));
                    write_reg(atp_pkg::CFG_IDLE_SLACK, 48'($urandom_range(0, 127)));
                    write_reg(atp_pkg::CFG_SURCHARGE, 48'($urandom_range(0, 65535)));
                    write_reg(atp_pkg::CFG_CAPACITY, rand_bytes());
                end
                default: begin
                    write_reg(atp_pkg::CFG_CYCLE_SLACK, 48'($urandom_range(0, 100)));
                    write_reg(atp_pkg::CFG_IDLE_SLACK, 48'($urandom_range(0, 100)));
                    write_reg(atp_pkg::CFG_SURCHARGE, 48'($urandom_range(200, 400)));
                    write_reg(atp_pkg::CFG_CAPACITY, rand_bytes());
                end
            endcase
            send_gap_pct = gap_set[ph];
            recv_stall_pct = stall_set[ph];
            for (int n = 0; n < 150; n++) begin
                // Hold off once per phase until the block has emptied.
                if (n == 75) begin
                    i_in_valid <= 1'b0;
                    do @(negedge i_clk); while (pending != 0);
                    @(posedge i_clk);
                end
                random_request();
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Sent %0d requests over four register settings and idle patterns;", sent);
        $display("compared %0d results, %0d of them denied claims.", checked, denied);
        if (errors == 0 && pending == 0) begin
            $display("allocation_tax_pacer_unit_tb passed");
        end else begin
            $display("allocation_tax_pacer_unit_tb failed");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #20ms;
        $display("Timeout with %0d results outstanding", pending);
        $display("allocation_tax_pacer_unit_tb failed");
        $finish;
    end
endmodule

// File: files.f
+incdir+rtl
rtl/atp_pkg.sv
rtl/atp_divider.sv
rtl/atp_mul.sv
rtl/allocation_tax_pacer_unit.sv
tb/pacer_checker.sv
tb/allocation_tax_pacer_unit_tb.sv
